### rtl/core/cbm_pkg.sv
// Shared types and constants for the cartridge bank mapper.
`default_nettype none

package cbm_pkg;

	localparam int unsigned FLASH_ADDR_BITS = 17;
	localparam int unsigned WINDOW_BITS     = 13;

	typedef enum logic [1:0] {
		REQ_READ   = 2'd0,
		REQ_WRITE  = 2'd1,
		REQ_FREEZE = 2'd2,
		REQ_RESET  = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		REGION_IO1   = 2'd0,
		REGION_IO2   = 2'd1,
		REGION_ROML  = 2'd2,
		REGION_ROMH  = 2'd3
	} region_t;

	typedef enum logic [1:0] {
		ROUTE_NONE  = 2'd0,
		ROUTE_REG   = 2'd1,
		ROUTE_RAM   = 2'd2,
		ROUTE_FLASH = 2'd3
	} route_t;

	typedef enum logic [1:0] {
		CFG_FLASH_JUMPER = 2'd0,
		CFG_BANK_JUMPER  = 2'd1,
		CFG_ALT_REVISION = 2'd2
	} cfg_index_t;

	localparam logic [WINDOW_BITS-1:0]     IO1_PAGE     = 13'h1e00;
	localparam logic [WINDOW_BITS-1:0]     IO2_PAGE     = 13'h1f00;
	localparam logic [FLASH_ADDR_BITS-1:0] FLASH_HI_BASE = 17'h10000;
	localparam logic [7:0]                 ALT_MASK     = 8'he7;
	localparam logic [7:0]                 ALT_PATTERN  = 8'h22;
	localparam logic [7:0]                 REG_CTRL     = 8'h00;
	localparam logic [7:0]                 REG_EXT      = 8'h01;

	typedef struct packed {
		logic [1:0]             req_type;
		logic [1:0]             region;
		logic [WINDOW_BITS-1:0] offset;
		logic [7:0]             wdata;
	} req_t;

	typedef struct packed {
		logic [1:0]                 route;
		logic [FLASH_ADDR_BITS-1:0] mem_addr;
		logic                       mem_write;
		logic [7:0]                 rdata;
		logic                       game_asserted;
		logic                       exrom_asserted;
		logic                       cart_active;
		logic                       freeze_allowed;
		logic                       clockport_on;
	} rsp_t;

endpackage

`default_nettype wire

### rtl/core/cbm_stream_if.sv
// Valid/ready channel carrying one payload per transaction.
`default_nettype none

interface cbm_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/core/cartridge_bank_mapper.sv
// Top level of the cartridge bank mapper: access decode, control state and result register.
//
//  channel | dir | payload                                        | transaction
//  --------+-----+------------------------------------------------+-------------------
//  in      | in  | req_type, region, offset, wdata                 | valid && ready
//  out     | out | route, mem_addr, mem_write, rdata, line flags   | valid && ready
//  cfg     | in  | cfg_index, cfg_wdata                            | cfg_we high
//
// One transaction per cycle while the result is not stalled. An access is held in the
// input register, is decoded against the control state there and lands in the result
// register. Control state updates as the access moves into the result register.
// A stalled result holds both stages; in.ready drops only when both are full.
// arst_n resets the control state (the cartridge comes up active) and clears both valid flags.
`default_nettype none

module cartridge_bank_mapper (
	input  wire logic       clk,
	input  wire logic       arst_n,
	cbm_stream_if.sink      in,
	cbm_stream_if.source    out,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [0:0] cfg_wdata
);

	localparam int unsigned AW = cbm_pkg::FLASH_ADDR_BITS;
	localparam int unsigned WW = cbm_pkg::WINDOW_BITS;

	logic flash_jumper_q, bank_jumper_q, alt_revision_q;

	logic       active_q, ram_mapped_q, allow_ram_bank_q, freeze_blocked_q;
	logic       reu_layout_q, ext_locked_q, ram_high_window_q, clockport_q;
	logic [3:0] bank_q;
	logic [1:0] map_mode_q;

	logic       active_d, ram_mapped_d, allow_ram_bank_d, freeze_blocked_d;
	logic       reu_layout_d, ext_locked_d, ram_high_window_d, clockport_d;
	logic [3:0] bank_d;
	logic [1:0] map_mode_d;

	cbm_pkg::req_t req_s1;
	logic          valid_s1;
	cbm_pkg::rsp_t rsp_q;
	logic          out_valid_q;

	logic advance;
	logic take_in;

	assign advance  = valid_s1 && (!out_valid_q || out.ready);
	assign take_in  = in.valid && in.ready;
	assign in.ready = !valid_s1 || advance;

	assign out.valid   = out_valid_q;
	assign out.payload = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_jumper_q <= 1'b0;
			bank_jumper_q  <= 1'b0;
			alt_revision_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cbm_pkg::CFG_FLASH_JUMPER: flash_jumper_q <= cfg_wdata[0];
				cbm_pkg::CFG_BANK_JUMPER:  bank_jumper_q  <= cfg_wdata[0];
				cbm_pkg::CFG_ALT_REVISION: alt_revision_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in.ready) begin
			valid_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			req_s1 <= in.payload;
		end
	end

	// Decode
	logic [7:0]    lo;
	logic [7:0]    v;
	logic          alt_high;
	logic [1:0]    route;
	logic          wr;
	logic          rd_status;
	logic [WW-1:0] flash_win;
	logic [WW-1:0] ram_page;
	logic [1:0]    ram_sel;
	logic [AW-1:0] flash_addr;
	logic [AW-1:0] ram_addr;
	logic [AW-1:0] addr;
	logic [7:0]    status;
	logic [3:0]    bank_from_v;

	assign lo          = req_s1.offset[7:0];
	assign v           = req_s1.wdata;
	assign alt_high    = alt_revision_q && ram_high_window_q;
	assign bank_from_v = {1'b0, v[7], v[4:3]};

	typedef enum logic [1:0] {
		RAM_IO1 = 2'd0,
		RAM_IO2 = 2'd1,
		RAM_ROML = 2'd2,
		RAM_ROMH = 2'd3
	} ram_sel_t;

	always_comb begin
		active_d          = active_q;
		bank_d            = bank_q;
		map_mode_d        = map_mode_q;
		ram_mapped_d      = ram_mapped_q;
		allow_ram_bank_d  = allow_ram_bank_q;
		freeze_blocked_d  = freeze_blocked_q;
		reu_layout_d      = reu_layout_q;
		ext_locked_d      = ext_locked_q;
		ram_high_window_d = ram_high_window_q;
		clockport_d       = clockport_q;
		route             = cbm_pkg::ROUTE_NONE;
		wr                = 1'b0;
		rd_status         = 1'b0;
		flash_win         = req_s1.offset;
		ram_sel           = RAM_ROMH;

		unique case (req_s1.req_type)
			cbm_pkg::REQ_RESET: begin
				active_d          = 1'b1;
				bank_d            = '0;
				map_mode_d        = flash_jumper_q ? 2'd2 : 2'd0;
				ram_mapped_d      = 1'b0;
				allow_ram_bank_d  = 1'b0;
				freeze_blocked_d  = 1'b0;
				reu_layout_d      = 1'b0;
				ext_locked_d      = 1'b0;
				ram_high_window_d = 1'b0;
				clockport_d       = 1'b0;
			end
			cbm_pkg::REQ_FREEZE: begin
				if (!flash_jumper_q && !freeze_blocked_q) begin
					active_d     = 1'b1;
					map_mode_d   = 2'd3;
					bank_d       = '0;
					ram_mapped_d = 1'b1;
				end
			end
			default: begin
				unique case (req_s1.region)
					cbm_pkg::REGION_IO1: begin
						flash_win = cbm_pkg::IO1_PAGE + WW'(lo);
						ram_sel   = RAM_IO1;
						if (active_q) begin
							priority if (lo == cbm_pkg::REG_CTRL
									&& req_s1.req_type == cbm_pkg::REQ_WRITE) begin
								bank_d = bank_from_v;
								if (alt_revision_q
										&& (v & cbm_pkg::ALT_MASK) == cbm_pkg::ALT_PATTERN) begin
									map_mode_d        = 2'd1;
									ram_mapped_d      = 1'b0;
									ram_high_window_d = 1'b1;
								end else begin
									map_mode_d        = v[1:0];
									ram_mapped_d      = v[5];
									ram_high_window_d = 1'b0;
								end
								if (v[2]) begin
									active_d = 1'b0;
								end
								route     = cbm_pkg::ROUTE_REG;
								rd_status = 1'b1;
							end else if (lo == cbm_pkg::REG_EXT
									&& req_s1.req_type == cbm_pkg::REQ_WRITE) begin
								if (flash_jumper_q) begin
									bank_d           = {bank_jumper_q & ~v[5], v[7], v[4:3]};
									allow_ram_bank_d = v[1];
									freeze_blocked_d = v[2];
									reu_layout_d     = 1'b0;
								end else if (!ext_locked_q) begin
									bank_d           = bank_from_v;
									allow_ram_bank_d = v[1];
									freeze_blocked_d = v[2];
									reu_layout_d     = v[6];
									clockport_d      = v[0];
									ext_locked_d     = 1'b1;
								end
								route     = cbm_pkg::ROUTE_REG;
								rd_status = 1'b1;
							end else if (lo <= cbm_pkg::REG_EXT) begin
								route     = cbm_pkg::ROUTE_REG;
								rd_status = 1'b1;
							end else if (reu_layout_q) begin
								if (ram_mapped_q) begin
									route = cbm_pkg::ROUTE_RAM;
									wr    = req_s1.req_type[0];
								end else if (req_s1.req_type == cbm_pkg::REQ_READ) begin
									route = cbm_pkg::ROUTE_FLASH;
								end
							end else begin
								route = cbm_pkg::ROUTE_NONE;
							end
						end
					end
					cbm_pkg::REGION_IO2: begin
						flash_win = cbm_pkg::IO2_PAGE + WW'(lo);
						ram_sel   = RAM_IO2;
						if (active_q && !reu_layout_q) begin
							if (req_s1.req_type == cbm_pkg::REQ_WRITE) begin
								if (ram_mapped_q) begin
									route = cbm_pkg::ROUTE_RAM;
									wr    = 1'b1;
								end
							end else if (ram_mapped_q || alt_high) begin
								route = cbm_pkg::ROUTE_RAM;
							end else begin
								route = cbm_pkg::ROUTE_FLASH;
							end
						end
					end
					cbm_pkg::REGION_ROML: begin
						ram_sel = RAM_ROML;
						if (ram_mapped_q) begin
							route = cbm_pkg::ROUTE_RAM;
							wr    = req_s1.req_type[0];
						end else if (req_s1.req_type == cbm_pkg::REQ_READ) begin
							route = cbm_pkg::ROUTE_FLASH;
						end else if (flash_jumper_q) begin
							route = cbm_pkg::ROUTE_FLASH;
							wr    = 1'b1;
						end
					end
					default: begin
						ram_sel = RAM_ROMH;
						if (alt_high) begin
							route = cbm_pkg::ROUTE_RAM;
							wr    = req_s1.req_type[0];
						end else if (req_s1.req_type == cbm_pkg::REQ_READ) begin
							route = cbm_pkg::ROUTE_FLASH;
						end
					end
				endcase
			end
		endcase
	end

	always_comb begin
		logic [AW-1:0] bank_off;
		logic          add_bank;
		bank_off   = {2'b00, bank_q[1:0], {WW{1'b0}}};
		flash_addr = (bank_jumper_q ? '0 : cbm_pkg::FLASH_HI_BASE)
			+ AW'(flash_win) + AW'({bank_q, {WW{1'b0}}});
		unique case (ram_sel)
			RAM_IO1:  ram_page = cbm_pkg::IO1_PAGE;
			RAM_IO2:  ram_page = cbm_pkg::IO2_PAGE;
			default:  ram_page = '0;
		endcase
		unique case (ram_sel)
			RAM_IO1, RAM_IO2: add_bank = allow_ram_bank_q;
			RAM_ROML:         add_bank = 1'b1;
			default:          add_bank = 1'b0;
		endcase
		if (ram_sel == RAM_IO1 || ram_sel == RAM_IO2) begin
			ram_addr = AW'(ram_page) + AW'(lo) + (add_bank ? bank_off : '0);
		end else begin
			ram_addr = AW'(req_s1.offset) + (add_bank ? bank_off : '0);
		end
		unique case (route)
			cbm_pkg::ROUTE_RAM:   addr = ram_addr;
			cbm_pkg::ROUTE_FLASH: addr = flash_addr;
			default:              addr = '0;
		endcase
	end

	assign status = {bank_d[2], reu_layout_d, bank_d[3], bank_d[1:0], 1'b0,
		allow_ram_bank_d, flash_jumper_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q          <= 1'b1;
			bank_q            <= '0;
			map_mode_q        <= 2'd0;
			ram_mapped_q      <= 1'b0;
			allow_ram_bank_q  <= 1'b0;
			freeze_blocked_q  <= 1'b0;
			reu_layout_q      <= 1'b0;
			ext_locked_q      <= 1'b0;
			ram_high_window_q <= 1'b0;
			clockport_q       <= 1'b0;
			out_valid_q       <= 1'b0;
		end else begin
			if (advance) begin
				active_q          <= active_d;
				bank_q            <= bank_d;
				map_mode_q        <= map_mode_d;
				ram_mapped_q      <= ram_mapped_d;
				allow_ram_bank_q  <= allow_ram_bank_d;
				freeze_blocked_q  <= freeze_blocked_d;
				reu_layout_q      <= reu_layout_d;
				ext_locked_q      <= ext_locked_d;
				ram_high_window_q <= ram_high_window_d;
				clockport_q       <= clockport_d;
				out_valid_q       <= 1'b1;
			end else if (out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.route          <= route;
			rsp_q.mem_addr       <= addr;
			rsp_q.mem_write      <= wr;
			rsp_q.rdata          <= rd_status ? status : 8'h00;
			rsp_q.game_asserted  <= map_mode_d[0];
			rsp_q.exrom_asserted <= ~map_mode_d[1];
			rsp_q.cart_active    <= active_d;
			rsp_q.freeze_allowed <= ~freeze_blocked_d;
			rsp_q.clockport_on   <= clockport_d;
		end
	end

endmodule

`default_nettype wire
